// ===== sv/xsfb_pkg.sv =====
// ----------------------------------------------------------------------------
// xsfb_pkg
// Shared types and constants of the XOR sprite framebuffer.
// ----------------------------------------------------------------------------
package xsfb_pkg;

    localparam int SCREEN_W = 64;
    localparam int SCREEN_H = 32;
    localparam int COL_W    = $clog2(SCREEN_W);
    localparam int ROW_W    = $clog2(SCREEN_H);
    localparam int SPRITE_W = 8;

    // Item kinds on the input side and result kinds on the output side.
    localparam logic [1:0] KIND_SPRITE = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_MOD
    } t_state;

    // Result of one row operation, handed from the row unit to the top level.
    typedef struct packed {
        logic [SCREEN_W-1:0] new_row;
        logic                hit;
        logic [SPRITE_W-1:0] pix;
    } t_rowop_res;

endpackage

// ===== sv/xsfb_ram.sv =====
// ----------------------------------------------------------------------------
// xsfb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module xsfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/xsfb_rowop.sv =====
// ----------------------------------------------------------------------------
// xsfb_rowop
// Row unit: XORs eight wrapped sprite pixels into one framebuffer row,
// detects erased pixels and extracts eight wrapped pixels for scan-out.
// ----------------------------------------------------------------------------
module xsfb_rowop
    import xsfb_pkg::*;
(
    input  logic [SCREEN_W-1:0] i_old_row,
    input  logic [COL_W-1:0]    i_col,
    input  logic [SPRITE_W-1:0] i_bits,
    output t_rowop_res          o_res
);

    logic [SCREEN_W-1:0] mask;
    logic [SPRITE_W-1:0] pix;
    logic [COL_W-1:0]    idx;

    // Column j of the window lands at (col + j) mod width; bit 7 is leftmost.
    always_comb begin
        mask = '0;
        pix  = '0;
        idx  = '0;
        for (int j = 0; j < SPRITE_W; j++) begin
            idx = i_col + COL_W'(j);
            mask[idx]            = i_bits[SPRITE_W-1-j];
            pix[SPRITE_W-1-j]    = i_old_row[idx];
        end
    end

    assign o_res.new_row = i_old_row ^ mask;
    assign o_res.hit     = |(i_old_row & mask);
    assign o_res.pix     = pix;

endmodule

// ===== sv/xor_sprite_framebuffer.sv =====
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer
// Monochrome framebuffer with XOR sprite rows, collision flag, clear and
// eight-pixel reads for scan-out.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata                                | tuser | tlast
//  --------+-----------+--------------------------------------+-------+---------
//  s       | in        | x_pos, y_pos, row_offset, row_bits   | kind  | last_row
//  m       | out       | collision, read_pixels               | r_kind| (none)
//
// In the accept cycle of an item the target row is read from the row RAM;
// in the ST_MOD state the row unit works on the registered read data and,
// once the item may finish, a sprite row is written back. The single RAM
// read port with its registered read data sets this split; no second item
// enters until the write has happened, so no forwarding is needed.
// Reset (synchronous, active low) clears the state machine, the output
// register, the collision flag and one valid bit per row; a row whose valid
// bit is low reads as all pixels off, so reset and the clear item take
// effect at once with no sweep over the RAM.
// An item that yields a result waits in ST_MOD while the output
// register still holds an earlier result that is not taken; the input side
// stays ready in the idle state regardless of the output side.
// ----------------------------------------------------------------------------
module xor_sprite_framebuffer
    import xsfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // [7:0] x_pos, [15:8] y_pos,
                                    // [23:16] row_offset, [31:24] row_bits
    input  logic [1:0]  i_s_tuser,  // [1:0] kind
    input  logic        i_s_tlast,  // last_row
    // Result item stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // [0] collision, [8:1] read_pixels,
                                    // [15:9] zero
    output logic [1:0]  o_m_tuser   // [1:0] result_kind
);

    t_state r_state, n_state;

    // Item held while it is worked on.
    logic [1:0]          r_kind;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [SPRITE_W-1:0] r_bits;
    logic                r_last;

    logic                r_acc, n_acc;
    logic [SCREEN_H-1:0] r_row_valid, n_row_valid;

    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_out_kind;
    logic                r_out_coll;
    logic [SPRITE_W-1:0] r_out_pix;

    logic [7:0]          s_x, s_y, s_roff, s_bits;
    logic                s_accept;
    logic [ROW_W-1:0]    s_row;

    logic                ram_we, ram_re;
    logic [SCREEN_W-1:0] ram_rdata, old_row;
    t_rowop_res          res;

    logic                need_out, go, acc_now;

    assign s_x    = i_s_tdata[7:0];
    assign s_y    = i_s_tdata[15:8];
    assign s_roff = i_s_tdata[23:16];
    assign s_bits = i_s_tdata[31:24];

    assign s_accept = i_s_tvalid && o_s_tready;

    // Sprite rows add the row offset; reads address y alone. Both wrap by masking.
    always_comb begin
        if (i_s_tuser == KIND_SPRITE) begin
            s_row = ROW_W'(s_y + s_roff);
        end else begin
            s_row = ROW_W'(s_y);
        end
    end

    xsfb_ram #(
        .WIDTH (SCREEN_W),
        .DEPTH (SCREEN_H)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_row),
        .i_wdata (res.new_row),
        .i_re    (ram_re),
        .i_raddr (s_row),
        .o_rdata (ram_rdata)
    );

    assign old_row = r_row_valid[r_row] ? ram_rdata : '0;

    xsfb_rowop u_rowop (
        .i_old_row (old_row),
        .i_col     (r_col),
        .i_bits    (r_bits),
        .o_res     (res)
    );

    // Which held items produce a result, and whether the output register is free.
    always_comb begin
        unique case (r_kind)
            KIND_SPRITE: need_out = r_last;
            KIND_CLEAR:  need_out = 1'b1;
            KIND_READ:   need_out = 1'b1;
            default:     need_out = 1'b0;
        endcase
    end

    assign go      = !need_out || !r_out_valid || i_m_tready;
    assign acc_now = r_acc | res.hit;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                if (go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        o_s_tready = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                ram_re     = i_s_tvalid;
            end
            ST_MOD: begin
                ram_we = go && (r_kind == KIND_SPRITE);
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    // Collision flag, row valid bits and output register.
    always_comb begin
        n_acc       = r_acc;
        n_row_valid = r_row_valid;
        n_out_valid = r_out_valid && !i_m_tready;
        if (r_state == ST_MOD && go) begin
            if (need_out) begin
                n_out_valid = 1'b1;
            end
            if (r_kind == KIND_SPRITE) begin
                n_acc              = r_last ? 1'b0 : acc_now;
                n_row_valid[r_row] = 1'b1;
            end else if (r_kind == KIND_CLEAR) begin
                n_acc       = 1'b0;
                n_row_valid = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= 1'b0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_row_valid <= n_row_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_kind <= i_s_tuser;
            r_col  <= COL_W'(s_x);
            r_row  <= s_row;
            r_bits <= s_bits;
            r_last <= i_s_tlast;
        end
        if (r_state == ST_MOD && go && need_out) begin
            r_out_kind <= r_kind;
            r_out_coll <= (r_kind == KIND_SPRITE) ? acc_now : 1'b0;
            r_out_pix  <= (r_kind == KIND_READ) ? res.pix : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_pix, r_out_coll};
    assign o_m_tuser  = r_out_kind;

endmodule
